// ===== hw/rtl/sjlw_pkg.sv =====
// Shared types and constants for the Shift-JIS line wrapper.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sjlw_pkg;

    // Register indexes of the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KANJI_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_ENABLED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_PER_PAGE = 2'd2;

    // Control characters
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // One configuration write
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } sjlw_cfg_wr_t;

    // Work for the back end: which words to send for one text byte
    typedef struct packed {
        logic       new_line;   // CR then LF
        logic       pause;      // pause request word
        logic       hi_en;      // lead byte of a double-byte character
        logic       lo_en;      // single byte or trail byte
        logic [7:0] hi_byte;
        logic [7:0] lo_byte;
    } sjlw_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/shiftjis_text_line_wrapper_unit.sv =====
// A text byte's first word passes the queue, the current-command and output registers.
// Throughput: one text byte accepted per cycle while the 4-entry command queue has room;
// the back end sends one word per cycle unless out_ready stalls it; a byte makes 0 to 5
// words, typically 1 or 2.
// Reset (rst_n, async, active low): column, row, held lead and queue cleared;
// kanji on, pausing off, 25 rows per page.
`default_nettype none

module shiftjis_text_line_wrapper_unit #(
    parameter int LINE_WIDTH = 80
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration write port
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    // text input
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    input  wire logic       start_of_text,
    // console output
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            pause_request,
    output logic            last
);
    import sjlw_pkg::*;

    sjlw_cfg_wr_t cfg;
    sjlw_cmd_t    push_cmd;
    sjlw_cmd_t    head_cmd;
    logic         push;
    logic         pop;
    logic         q_full;
    logic         q_not_empty;

    always_comb
    begin
        cfg.we    = cfg_we;
        cfg.index = cfg_index;
        cfg.data  = cfg_data;
    end

    sjlw_front #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_byte     (text_byte),
        .start_of_text (start_of_text),
        .queue_full    (q_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    sjlw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    sjlw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_cmd         (head_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .pause_request (pause_request),
        .last          (last)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sjlw_front.sv =====
// Front end: accepts text bytes, joins Shift-JIS pairs, tracks column and row,
// and issues at most one command per text byte. Holds the configuration registers.
// Depends on sjlw_pkg.
`default_nettype none

module sjlw_front #(
    parameter int LINE_WIDTH = 80
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sjlw_pkg::sjlw_cfg_wr_t cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 start_of_text,
    input  wire logic                 queue_full,
    output logic                      push,
    output sjlw_pkg::sjlw_cmd_t       push_cmd
);
    import sjlw_pkg::*;

    localparam logic [6:0] LW_C  = 7'(LINE_WIDTH);
    localparam logic [6:0] LW_M1 = 7'(LINE_WIDTH - 1);

    function automatic logic is_lead(input logic [7:0] b);
        is_lead = (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hEF);
    endfunction

    function automatic logic is_trail(input logic [7:0] b);
        is_trail = (b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC);
    endfunction

    logic       kanji_en_reg;
    logic       pause_en_reg;
    logic [7:0] rows_per_page_reg;

    logic [7:0] held_reg,  held_next;
    logic       pend_reg,  pend_next;
    logic [6:0] col_reg,   col_next;
    logic [7:0] row_reg,   row_next;

    logic       accept;
    logic [7:0] st_held;
    logic       st_pend;
    logic [6:0] st_col;
    logic [7:0] st_row;
    logic       hold;
    logic       is_double;
    logic [7:0] hi_b;
    logic       code_lf;
    logic       code_cr;
    logic       narrow_dbl;
    logic       wide;
    logic       valid_dbl;
    logic       nl;
    logic [7:0] row_after;
    logic       pause;
    logic       emit;
    logic [6:0] col_after;
    logic [6:0] col_final;
    logic [7:0] row_final;
    logic       any_word;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Classify the byte against the state after an optional start of text
    always_comb
    begin
        st_held = start_of_text ? 8'h00 : held_reg;
        st_pend = start_of_text ? 1'b0  : pend_reg;
        st_col  = start_of_text ? 7'd0  : col_reg;
        st_row  = start_of_text ? 8'h00 : row_reg;

        hold      = 1'b0;
        is_double = 1'b0;
        hi_b      = 8'h00;
        if (st_pend)
        begin
            is_double = 1'b1;
            hi_b      = st_held;
        end
        else if (kanji_en_reg && is_lead(text_byte))
        begin
            hold = 1'b1;
        end

        code_lf    = !is_double && (text_byte == CHAR_LF);
        code_cr    = !is_double && (text_byte == CHAR_CR);
        // codes 0x8540-0x869D are single width
        narrow_dbl = (hi_b == 8'h85 && text_byte >= 8'h40) ||
                     (hi_b == 8'h86 && text_byte <= 8'h9D);
        wide       = is_double && !narrow_dbl;
        valid_dbl  = is_lead(hi_b) && is_trail(text_byte);

        nl = code_lf || (st_col >= LW_C) ||
             ((st_col == LW_M1) && is_double && valid_dbl && wide);

        row_after = nl ? st_row + 8'd1 : st_row;
        pause     = pause_en_reg && (rows_per_page_reg != 8'h00) &&
                    (row_after == rows_per_page_reg);
        row_final = pause ? 8'h00 : row_after;

        emit      = !code_lf && !code_cr;
        col_after = nl ? 7'd0 : st_col;
        col_final = emit ? col_after + (wide ? 7'd2 : 7'd1) : col_after;

        any_word  = nl || pause || emit;
    end

    // Command for the back end
    always_comb
    begin
        push_cmd.new_line = nl;
        push_cmd.pause    = pause;
        push_cmd.hi_en    = emit && is_double;
        push_cmd.lo_en    = emit;
        push_cmd.hi_byte  = hi_b;
        push_cmd.lo_byte  = text_byte;
    end

    assign push = accept && !hold && any_word;

    // Next state
    always_comb
    begin
        held_next = held_reg;
        pend_next = pend_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (accept)
        begin
            if (hold)
            begin
                held_next = text_byte;
                pend_next = 1'b1;
                col_next  = st_col;
                row_next  = st_row;
            end
            else
            begin
                held_next = 8'h00;
                pend_next = 1'b0;
                col_next  = col_final;
                row_next  = row_final;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 8'h00;
            pend_reg <= 1'b0;
            col_reg  <= 7'd0;
            row_reg  <= 8'h00;
        end
        else
        begin
            held_reg <= held_next;
            pend_reg <= pend_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kanji_en_reg      <= 1'b1;
            pause_en_reg      <= 1'b0;
            rows_per_page_reg <= 8'd25;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                CFG_KANJI_ENABLED: kanji_en_reg      <= cfg.data[0];
                CFG_PAUSE_ENABLED: pause_en_reg      <= cfg.data[0];
                CFG_ROWS_PER_PAGE: rows_per_page_reg <= cfg.data;
                default:           ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sjlw_queue.sv =====
// Command queue between front and back end: small register FIFO.
// Depends on sjlw_pkg.
`default_nettype none

module sjlw_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire sjlw_pkg::sjlw_cmd_t push_cmd,
    input  wire logic                pop,
    output logic                     full,
    output logic                     not_empty,
    output sjlw_pkg::sjlw_cmd_t      head_cmd
);
    import sjlw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sjlw_cmd_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    assign full      = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_cmd  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sjlw_back.sv =====
// Back end: expands each queued command into output words, one a cycle unless
// out_ready stalls it, through a registered output stage. Depends on sjlw_pkg.
`default_nettype none

module sjlw_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_not_empty,
    input  wire sjlw_pkg::sjlw_cmd_t q_cmd,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               out_byte,
    output logic                     pause_request,
    output logic                     last
);
    import sjlw_pkg::*;

    // Word slots in send order
    localparam int SLOT_CR    = 4;
    localparam int SLOT_LF    = 3;
    localparam int SLOT_PAUSE = 2;
    localparam int SLOT_HI    = 1;
    localparam int SLOT_LO    = 0;

    logic       cur_valid_reg, cur_valid_next;
    logic [4:0] cur_mask_reg,  cur_mask_next;
    logic [7:0] cur_hi_reg,    cur_hi_next;
    logic [7:0] cur_lo_reg,    cur_lo_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg,  out_byte_next;
    logic       out_pause_reg, out_pause_next;
    logic       out_last_reg,  out_last_next;

    logic       adv;
    logic [4:0] sel;
    logic [4:0] mask_rem;
    logic       done;
    logic [7:0] sel_byte;
    logic       sel_pause;

    // Pick the first pending word of the current command
    always_comb
    begin
        sel       = '0;
        sel_byte  = cur_lo_reg;
        sel_pause = 1'b0;
        if (cur_mask_reg[SLOT_CR])
        begin
            sel[SLOT_CR] = 1'b1;
            sel_byte     = CHAR_CR;
        end
        else if (cur_mask_reg[SLOT_LF])
        begin
            sel[SLOT_LF] = 1'b1;
            sel_byte     = CHAR_LF;
        end
        else if (cur_mask_reg[SLOT_PAUSE])
        begin
            sel[SLOT_PAUSE] = 1'b1;
            sel_byte        = 8'h00;
            sel_pause       = 1'b1;
        end
        else if (cur_mask_reg[SLOT_HI])
        begin
            sel[SLOT_HI] = 1'b1;
            sel_byte     = cur_hi_reg;
        end
        else
        begin
            sel[SLOT_LO] = 1'b1;
        end
        mask_rem = cur_mask_reg & ~sel;
        done     = (mask_rem == '0);
    end

    assign adv = cur_valid_reg && (!out_valid_reg || out_ready);
    assign pop = q_not_empty && (!cur_valid_reg || (adv && done));

    // Current command
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_mask_next  = cur_mask_reg;
        cur_hi_next    = cur_hi_reg;
        cur_lo_next    = cur_lo_reg;
        if (adv)
        begin
            cur_mask_next = mask_rem;
            if (done)
                cur_valid_next = 1'b0;
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_mask_next  = {q_cmd.new_line, q_cmd.new_line, q_cmd.pause,
                              q_cmd.hi_en, q_cmd.lo_en};
            cur_hi_next    = q_cmd.hi_byte;
            cur_lo_next    = q_cmd.lo_byte;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_pause_next = out_pause_reg;
        out_last_next  = out_last_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = sel_byte;
            out_pause_next = sel_pause;
            out_last_next  = done;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_mask_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cur_mask_reg  <= cur_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_hi_reg    <= cur_hi_next;
        cur_lo_reg    <= cur_lo_next;
        out_byte_reg  <= out_byte_next;
        out_pause_reg <= out_pause_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign pause_request = out_pause_reg;
    assign last          = out_last_reg;

endmodule

`default_nettype wire
